// ===== hdl/cae_pkg.sv =====
package cae_pkg;

    // Register index field covers up to this many architectural registers
    localparam int REG_SLOTS = 16;

    localparam logic [31:0] MEMORY_BASE_RESET = 32'h0000_0100;

    // Instruction kinds
    localparam logic [3:0] KIND_ADD    = 4'd0;
    localparam logic [3:0] KIND_SUB    = 4'd1;
    localparam logic [3:0] KIND_AND    = 4'd2;
    localparam logic [3:0] KIND_ORR    = 4'd3;
    localparam logic [3:0] KIND_EOR    = 4'd4;
    localparam logic [3:0] KIND_MOV    = 4'd5;
    localparam logic [3:0] KIND_MVN    = 4'd6;
    localparam logic [3:0] KIND_CMP    = 4'd7;
    localparam logic [3:0] KIND_LDR    = 4'd8;
    localparam logic [3:0] KIND_STR    = 4'd9;
    localparam logic [3:0] KIND_LSL    = 4'd10;
    localparam logic [3:0] KIND_LSR    = 4'd11;
    localparam logic [3:0] KIND_BRANCH = 4'd12;

    // Condition codes
    localparam logic [2:0] COND_AL = 3'd0;
    localparam logic [2:0] COND_EQ = 3'd1;
    localparam logic [2:0] COND_NE = 3'd2;
    localparam logic [2:0] COND_GT = 3'd3;
    localparam logic [2:0] COND_GE = 3'd4;
    localparam logic [2:0] COND_LT = 3'd5;
    localparam logic [2:0] COND_LE = 3'd6;

    typedef struct packed {
        logic [3:0]  kind;
        logic [2:0]  cond;
        logic        set_flags;
        logic [3:0]  dest_reg;
        logic [3:0]  first_reg;
        logic        use_immediate;
        logic [3:0]  second_reg;
        logic [31:0] immediate;
    } cae_in_t;

    typedef struct packed {
        logic        executed;
        logic [31:0] result_value;
        logic        flag_n;
        logic        flag_z;
        logic        flag_c;
        logic        flag_v;
        logic        branch_taken;
        logic        address_error;
    } cae_out_t;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } flags_t;

    // Control produced by the execute logic for one instruction
    typedef struct packed {
        logic executed;
        logic reg_we;
        logic load;
        logic store;
        logic taken;
        logic aerr;
    } exec_ctl_t;

endpackage

// ===== hdl/cae_req_if.sv =====
interface cae_req_if;
    import cae_pkg::*;

    logic    valid;
    logic    ready;
    cae_in_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/cae_rsp_if.sv =====
interface cae_rsp_if;
    import cae_pkg::*;

    logic     valid;
    logic     ready;
    cae_out_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/conditional_alu_execute_unit.sv =====
// Conditional ALU execute unit with NZCV flags.
// req carries one decoded instruction per beat; rsp returns exactly one
// result beat per instruction, in order. cfg_wr_en/cfg_wr_data write the
// memory base address; write it only while no instruction is in flight.
// Each accepted beat is registered, then executed in one pass against the
// register file, flags and data memory, and its result is registered.
// Accepted beats pass the input register and then the result register.
// Throughput: one instruction per cycle unless rsp stalls or memory clears;
// results reach the next instruction without bubbles (load data is bypassed
// from the memory read register while the register file write completes).
// Load results come from the data RAM's registered read port; a load's
// result_value is taken from that port while the beat waits on rsp.
// Reset: registers and flags clear at once, memory base goes to 0x100,
// and the data memory is cleared by a pass over every word during
// which req.ready stays low.
// When rsp stalls the result beat holds; one more beat may be accepted
// into the input register, then req.ready drops until rsp moves.
module conditional_alu_execute_unit #(
    parameter int MEM_WORDS = 8,
    parameter int NUM_REGS  = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    cae_req_if.sink     req,
    cae_rsp_if.source   rsp
);
    import cae_pkg::*;

    localparam int               IDX_W    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MEM_WORDS - 1);

    // Input register
    logic        s1_valid_reg;
    cae_in_t     s1_data_reg;
    // Result register
    logic        o_valid_reg;
    logic        o_load_reg;
    cae_out_t    o_data_reg;
    cae_out_t    rsp_payload;
    // Architectural state
    logic [31:0] regs_reg [NUM_REGS];
    flags_t      flags_reg;
    logic [31:0] base_reg;
    // Load writeback pending for one cycle
    logic        lw_pend_reg;
    logic [3:0]  lw_rd_reg;
    // Memory clearing pass
    logic             clearing_reg;
    logic [IDX_W-1:0] clear_cnt_reg;

    logic [31:0]      rf_view [REG_SLOTS];
    logic             advance;
    exec_ctl_t        ctl;
    logic [31:0]      alu_value;
    flags_t           alu_flags;
    logic [IDX_W-1:0] mem_idx;
    logic             ram_we;
    logic             ram_re;
    logic [IDX_W-1:0] ram_addr;
    logic [31:0]      ram_wdata;
    logic [31:0]      ram_rdata;

    // Handshake
    assign advance   = s1_valid_reg && (!o_valid_reg || rsp.ready);
    assign req.ready = !clearing_reg && (!s1_valid_reg || advance);

    // Register read view with load bypass; missing registers read zero
    for (genvar i = 0; i < REG_SLOTS; i++)
    begin : g_view
        if (i < NUM_REGS)
        begin : g_live
            assign rf_view[i] = (lw_pend_reg && (lw_rd_reg == 4'(i))) ? ram_rdata
                                                                        : regs_reg[i];
        end
        else
        begin : g_none
            assign rf_view[i] = '0;
        end
    end

    cae_alu #(
        .MEM_WORDS (MEM_WORDS)
    ) u_alu (
        .instr      (s1_data_reg),
        .op_a       (rf_view[s1_data_reg.first_reg]),
        .op_m       (rf_view[s1_data_reg.second_reg]),
        .op_d       (rf_view[s1_data_reg.dest_reg]),
        .flags      (flags_reg),
        .mem_base   (base_reg),
        .ctl        (ctl),
        .value      (alu_value),
        .flags_next (alu_flags),
        .mem_idx    (mem_idx)
    );

    // Data memory port: clearing pass, store or load
    assign ram_we    = clearing_reg || (advance && ctl.store);
    assign ram_re    = advance && ctl.load;
    assign ram_addr  = clearing_reg ? clear_cnt_reg : mem_idx;
    assign ram_wdata = clearing_reg ? 32'd0 : alu_value;

    cae_ram #(
        .WIDTH (32),
        .DEPTH (MEM_WORDS)
    ) u_dmem (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clear_cnt_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clear_cnt_reg <= clear_cnt_reg + 1'b1;
            if (clear_cnt_reg == LAST_IDX)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= MEMORY_BASE_RESET;
        end
        else if (cfg_wr_en)
        begin
            base_reg <= cfg_wr_data;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_data_reg <= req.payload;
        end
    end

    // Register file, flags and load writeback; execute write wins over load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                regs_reg[i] <= '0;
            end
            flags_reg   <= '0;
            lw_pend_reg <= 1'b0;
            lw_rd_reg   <= '0;
        end
        else
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                if (advance && ctl.reg_we && (s1_data_reg.dest_reg == 4'(i)))
                begin
                    regs_reg[i] <= alu_value;
                end
                else if (lw_pend_reg && (lw_rd_reg == 4'(i)))
                begin
                    regs_reg[i] <= ram_rdata;
                end
            end
            if (advance)
            begin
                flags_reg <= alu_flags;
            end
            lw_pend_reg <= advance && ctl.load;
            lw_rd_reg   <= s1_data_reg.dest_reg;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            o_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            o_load_reg                <= ctl.load;
            o_data_reg.executed       <= ctl.executed;
            o_data_reg.result_value   <= alu_value;
            o_data_reg.flag_n         <= alu_flags.n;
            o_data_reg.flag_z         <= alu_flags.z;
            o_data_reg.flag_c         <= alu_flags.c;
            o_data_reg.flag_v         <= alu_flags.v;
            o_data_reg.branch_taken   <= ctl.taken;
            o_data_reg.address_error  <= ctl.aerr;
        end
    end

    // Loaded word comes from the RAM read register, held until the next read
    always_comb
    begin
        rsp_payload = o_data_reg;
        if (o_load_reg)
        begin
            rsp_payload.result_value = ram_rdata;
        end
    end

    assign rsp.valid   = o_valid_reg;
    assign rsp.payload = rsp_payload;

`ifndef ASSERT_OFF
    // No instruction enters while the memory is being cleared
    a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !s1_valid_reg && !o_valid_reg)
        else $error("instruction in flight during memory clearing");

    // A pending load writeback always follows an executed load
    a_load_wb_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
        lw_pend_reg |-> $past(advance) && o_valid_reg && o_load_reg)
        else $error("load writeback without a preceding load");

    // Address errors never report as executed
    a_aerr_not_executed: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.payload.address_error |-> !rsp.payload.executed)
        else $error("address error reported as executed");

    // A taken branch is always an executed item with a zero result
    a_branch_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.payload.branch_taken
            |-> rsp.payload.executed && (rsp.payload.result_value == 32'd0))
        else $error("taken branch with bad result fields");
`endif
endmodule

// ===== hdl/cae_ram.sv =====
module cae_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port: write, or registered read that holds until the next read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== hdl/cae_alu.sv =====
module cae_alu #(
    parameter int MEM_WORDS = 8
) (
    input  cae_pkg::cae_in_t   instr,
    input  logic [31:0]        op_a,
    input  logic [31:0]        op_m,
    input  logic [31:0]        op_d,
    input  cae_pkg::flags_t    flags,
    input  logic [31:0]        mem_base,
    output cae_pkg::exec_ctl_t ctl,
    output logic [31:0]        value,
    output cae_pkg::flags_t    flags_next,
    output logic [(MEM_WORDS > 1 ? $clog2(MEM_WORDS) : 1)-1:0] mem_idx
);
    import cae_pkg::*;

    localparam int          IDX_W     = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam logic [31:0] MEM_BYTES = 32'(4 * MEM_WORDS);

    logic        cond_ok;
    logic [31:0] b;
    logic [31:0] sub_a;
    logic [32:0] sum;
    logic [32:0] diff;
    logic [32:0] addr_off;
    logic        in_range;
    logic        shift_big;
    logic [31:0] logic_r;
    flags_t      sub_flags;

    assign b = instr.use_immediate ? instr.immediate : op_m;

    // Condition check against the current flags
    always_comb
    begin
        unique case (instr.cond)
            COND_AL: cond_ok = 1'b1;
            COND_EQ: cond_ok = flags.z;
            COND_NE: cond_ok = !flags.z;
            COND_GT: cond_ok = !flags.z && (flags.n == flags.v);
            COND_GE: cond_ok = (flags.n == flags.v);
            COND_LT: cond_ok = (flags.n != flags.v);
            COND_LE: cond_ok = flags.z || (flags.n != flags.v);
            default: cond_ok = 1'b0;
        endcase
    end

    // Adder, and subtractor shared by SUB and CMP; CMP subtracts from the dest register
    assign sum   = {1'b0, op_a} + {1'b0, b};
    assign sub_a = (instr.kind == KIND_CMP) ? op_d : op_a;
    assign diff  = {1'b0, sub_a} - {1'b0, b};

    assign sub_flags.n = diff[31];
    assign sub_flags.z = (diff[31:0] == 32'd0);
    assign sub_flags.c = !diff[32];
    assign sub_flags.v = ((sub_a[31] ^ b[31]) & (sub_a[31] ^ diff[31]));

    // Load/store address check relative to the memory base
    assign addr_off = {1'b0, b} - {1'b0, mem_base};
    assign in_range = !addr_off[32] && (addr_off[31:0] < MEM_BYTES);
    assign mem_idx  = addr_off[IDX_W+1:2];

    assign shift_big = |instr.immediate[31:5];

    always_comb
    begin
        unique case (instr.kind)
            KIND_AND: logic_r = op_a & b;
            KIND_ORR: logic_r = op_a | b;
            default:  logic_r = op_a ^ b;
        endcase
    end

    // Per-kind effect
    always_comb
    begin
        ctl        = '0;
        value      = '0;
        flags_next = flags;
        if (cond_ok)
        begin
            unique case (instr.kind)
                KIND_ADD:
                begin
                    ctl.executed = 1'b1;
                    ctl.reg_we   = 1'b1;
                    value        = sum[31:0];
                    if (instr.set_flags)
                    begin
                        flags_next.n = sum[31];
                        flags_next.z = (sum[31:0] == 32'd0);
                        flags_next.c = sum[32];
                        flags_next.v = ~(op_a[31] ^ b[31]) & (op_a[31] ^ sum[31]);
                    end
                end
                KIND_SUB:
                begin
                    ctl.executed = 1'b1;
                    ctl.reg_we   = 1'b1;
                    value        = diff[31:0];
                    if (instr.set_flags)
                    begin
                        flags_next = sub_flags;
                    end
                end
                KIND_AND, KIND_ORR, KIND_EOR:
                begin
                    ctl.executed = 1'b1;
                    ctl.reg_we   = 1'b1;
                    value        = logic_r;
                    if (instr.set_flags)
                    begin
                        flags_next.n = logic_r[31];
                        flags_next.z = (logic_r == 32'd0);
                    end
                end
                KIND_MOV:
                begin
                    ctl.executed = 1'b1;
                    ctl.reg_we   = 1'b1;
                    value        = b;
                end
                KIND_MVN:
                begin
                    ctl.executed = 1'b1;
                    ctl.reg_we   = 1'b1;
                    value        = ~b;
                end
                KIND_CMP:
                begin
                    ctl.executed = 1'b1;
                    flags_next   = sub_flags;
                end
                KIND_LDR:
                begin
                    if (in_range)
                    begin
                        ctl.executed = 1'b1;
                        ctl.load     = 1'b1;
                    end
                    else
                    begin
                        ctl.aerr = 1'b1;
                    end
                end
                KIND_STR:
                begin
                    if (in_range)
                    begin
                        ctl.executed = 1'b1;
                        ctl.store    = 1'b1;
                        value        = op_d;
                    end
                    else
                    begin
                        ctl.aerr = 1'b1;
                    end
                end
                KIND_LSL:
                begin
                    ctl.executed = 1'b1;
                    ctl.reg_we   = 1'b1;
                    value        = shift_big ? 32'd0 : (op_a << instr.immediate[4:0]);
                end
                KIND_LSR:
                begin
                    ctl.executed = 1'b1;
                    ctl.reg_we   = 1'b1;
                    value        = shift_big ? 32'd0 : (op_a >> instr.immediate[4:0]);
                end
                KIND_BRANCH:
                begin
                    ctl.executed = 1'b1;
                    ctl.taken    = 1'b1;
                end
                default:
                begin
                    ctl.executed = 1'b0;
                end
            endcase
        end
    end
endmodule
